/* hdl/substring_char_translate_assert.svh */
// Assertion macros shared by the translator RTL.
`ifndef SUBSTRING_CHAR_TRANSLATE_ASSERT_SVH
`define SUBSTRING_CHAR_TRANSLATE_ASSERT_SVH

// Same-cycle implication, clocked on clock, off during reset.
`define STC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, clocked on clock, off during reset.
`define STC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/stc_pkg.sv */
// Types and constants of the windowed byte translator.
package stc_pkg;

   typedef logic [2:0] csr_index_type;

   localparam csr_index_type CSR_WINDOW_START  = 3'd0;
   localparam csr_index_type CSR_WINDOW_LENGTH = 3'd1;
   localparam csr_index_type CSR_SOURCE_LENGTH = 3'd2;
   localparam csr_index_type CSR_PAD_BYTE      = 3'd3;
   localparam csr_index_type CSR_IN_MAP_LEN    = 3'd4;
   localparam csr_index_type CSR_OUT_MAP_LEN   = 3'd5;

   localparam logic [7:0] PAD_BYTE_RESET = 8'd32;

   typedef struct packed {
      logic       mode;
      logic [5:0] map_index;
      logic [7:0] in_map_byte;
      logic [7:0] out_map_byte;
      logic [7:0] data_byte;
      logic       last_of_string;
   } req_word_type;

   typedef struct packed {
      logic [16:0] window_start;
      logic [16:0] window_length;
      logic [15:0] source_length;
   } win_cfg_type;

   typedef struct packed {
      logic        empty;
      logic [15:0] first;
      logic [15:0] last_pos;
   } window_type;

   typedef struct packed {
      logic [6:0] in_map_len;
      logic [6:0] out_map_len;
      logic [7:0] pad_byte;
   } cell_cfg_type;

   typedef struct packed {
      logic       is_load;
      logic [5:0] map_index;
      logic [7:0] in_map_byte;
      logic [7:0] out_map_byte;
      logic [7:0] data_byte;
      logic [7:0] result;
      logic       kept;
      logic       last_kept;
      logic       status;
      logic       found;
   } item_type;

endpackage

/* hdl/stc_if.sv */
// Channel interfaces of the translator: request, response and register write.
interface stc_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [5:0] map_index;
   logic [7:0] in_map_byte;
   logic [7:0] out_map_byte;
   logic [7:0] data_byte;
   logic       last_of_string;

   modport source (output valid, mode, map_index, in_map_byte, out_map_byte, data_byte,
                   last_of_string, input ready);
   modport sink (input valid, mode, map_index, in_map_byte, out_map_byte, data_byte,
                 last_of_string, output ready);
endinterface

interface stc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       kept;
   logic       last_kept;
   logic       status;

   modport source (output valid, out_byte, kept, last_kept, status, input ready);
   modport sink (input valid, out_byte, kept, last_kept, status, output ready);
endinterface

interface stc_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [16:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* hdl/substring_char_translate.sv */
// Windowed byte translator: a position/window front stage feeding a row of map cells.
//
// Channels: req_ch takes one word per handshake, either a map pair load (mode 0,
// stored at map_index) or a source byte (mode 1, last_of_string ends the string).
// rsp_ch returns exactly one word per request word, in order: out_byte, kept,
// last_kept and status (bad_length). A load returns a word of zeros.
// csr_ch writes the window, source length, pad byte and map lengths; it is always
// ready; the user must write it only while no word is in flight, not enforced here.
// Path: a word accepted on req_ch is registered in the front stage, then in each
// map cell in turn, and rsp_ch shows the last cell's register.
// Throughput is one word per cycle while rsp_ch does not stall:
// every cell compares the word passing it while it hands the previous word on.
// A load travels the same row and writes its cell on the way, so words behind it
// see the new pair and words ahead of it do not.
// Reset clears the byte position, the registers (pad byte to 32) and all valid flags;
// map contents stay undefined until loaded.
// A stall on rsp_ch holds the whole row, and req_ch.ready drops until the output
// word is taken.
`include "substring_char_translate_assert.svh"

module substring_char_translate #(
   parameter int MAP_DEPTH = 64,
   parameter int POS_WIDTH = 16
) (
   input logic      clock,
   input logic      reset,
   stc_req_if.sink  req_ch,
   stc_rsp_if.source rsp_ch,
   stc_csr_if.sink  csr_ch
);
   import stc_pkg::*;

   logic [16:0] window_start_ff, window_length_ff;
   logic [15:0] source_length_ff;
   logic [7:0]  pad_byte_ff;
   logic [6:0]  in_map_len_ff, out_map_len_ff;

   logic         advance, take, csr_write;
   req_word_type word;
   win_cfg_type  win_cfg;
   cell_cfg_type cell_cfg;

   logic [MAP_DEPTH:0] stage_valid;
   item_type           stage_item [MAP_DEPTH+1];

   assign csr_ch.ready = 1'b1;
   assign csr_write    = csr_ch.valid && csr_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_start_ff  <= '0;
         window_length_ff <= '0;
         source_length_ff <= '0;
         pad_byte_ff      <= PAD_BYTE_RESET;
         in_map_len_ff    <= '0;
         out_map_len_ff   <= '0;
      end else if (csr_write) begin
         case (csr_ch.index)
            CSR_WINDOW_START:  window_start_ff  <= csr_ch.data;
            CSR_WINDOW_LENGTH: window_length_ff <= csr_ch.data;
            CSR_SOURCE_LENGTH: source_length_ff <= csr_ch.data[15:0];
            CSR_PAD_BYTE:      pad_byte_ff      <= csr_ch.data[7:0];
            CSR_IN_MAP_LEN:    in_map_len_ff    <= csr_ch.data[6:0];
            CSR_OUT_MAP_LEN:   out_map_len_ff   <= csr_ch.data[6:0];
            default: ;
         endcase
      end
   end

   // Advance the row unless the output word is stuck.
   assign advance      = !stage_valid[MAP_DEPTH] || rsp_ch.ready;
   assign req_ch.ready = advance;
   assign take         = req_ch.valid && advance;

   always_comb begin
      word.mode           = req_ch.mode;
      word.map_index      = req_ch.map_index;
      word.in_map_byte    = req_ch.in_map_byte;
      word.out_map_byte   = req_ch.out_map_byte;
      word.data_byte      = req_ch.data_byte;
      word.last_of_string = req_ch.last_of_string;

      win_cfg.window_start  = window_start_ff;
      win_cfg.window_length = window_length_ff;
      win_cfg.source_length = source_length_ff;

      cell_cfg.in_map_len  = in_map_len_ff;
      cell_cfg.out_map_len = out_map_len_ff;
      cell_cfg.pad_byte    = pad_byte_ff;
   end

   stc_front #(.POS_WIDTH(POS_WIDTH)) u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .take      (take),
      .word      (word),
      .cfg       (win_cfg),
      .out_valid (stage_valid[0]),
      .out_item  (stage_item[0])
   );

   for (genvar k = 0; k < MAP_DEPTH; k++) begin : g_cell
      stc_cell #(.CELL_ID(k)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (stage_valid[k]),
         .in_item   (stage_item[k]),
         .cfg       (cell_cfg),
         .out_valid (stage_valid[k+1]),
         .out_item  (stage_item[k+1])
      );
   end

   assign rsp_ch.valid     = stage_valid[MAP_DEPTH];
   assign rsp_ch.out_byte  = stage_item[MAP_DEPTH].result;
   assign rsp_ch.kept      = stage_item[MAP_DEPTH].kept;
   assign rsp_ch.last_kept = stage_item[MAP_DEPTH].last_kept;
   assign rsp_ch.status    = stage_item[MAP_DEPTH].status;

   `STC_ASSERT_NOW(a_stall_blocks_req, rsp_ch.valid && !rsp_ch.ready, !req_ch.ready, "request taken while output stalled")
   `STC_ASSERT_NOW(a_kept_not_bad, rsp_ch.valid && rsp_ch.kept, !rsp_ch.status, "kept word flagged bad_length")
   `STC_ASSERT_NEXT(a_take_enters_row, req_ch.valid && req_ch.ready, stage_valid[0], "accepted word missing from front stage")

endmodule

/* hdl/stc_front.sv */
// Front stage: byte position counter, window resolution and window test.
module stc_front #(
   parameter int POS_WIDTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 take,
   input  stc_pkg::req_word_type word,
   input  stc_pkg::win_cfg_type  cfg,
   output logic                 out_valid,
   output stc_pkg::item_type     out_item
);
   import stc_pkg::*;

   localparam int CMP_WIDTH = (POS_WIDTH > 16) ? POS_WIDTH : 16;

   logic [POS_WIDTH-1:0] pos_ff, pos_in;
   logic [POS_WIDTH-1:0] hold_pos_ff;
   logic                 hold_valid_ff, hold_valid_in;
   req_word_type         word_ff;
   window_type           win_ff, win_in;

   logic signed [18:0] start_s, len_s, src_s, begin_s, len0_s, end_raw_s, end_s, first_s;
   logic               start_pos, start_zero, len_zero;
   logic [CMP_WIDTH-1:0] p_cmp, first_cmp, last_cmp;
   logic                 bad, in_win;

   // Position counter: clear after the last byte, saturate at all ones.
   always_comb begin
      pos_in = pos_ff;
      if (take && word.mode) begin
         if (word.last_of_string) begin
            pos_in = '0;
         end else if (!(&pos_ff)) begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   assign hold_valid_in = advance ? take : hold_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         hold_valid_ff <= 1'b0;
      end else begin
         pos_ff        <= pos_in;
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         word_ff     <= word;
         hold_pos_ff <= pos_ff;
      end
      win_ff <= win_in;
   end

   // Resolve the window into first byte and last byte, clipped to the source.
   always_comb begin
      start_s    = {{2{cfg.window_start[16]}}, cfg.window_start};
      len_s      = {{2{cfg.window_length[16]}}, cfg.window_length};
      src_s      = {3'b000, cfg.source_length};
      start_zero = (cfg.window_start == '0);
      start_pos  = !cfg.window_start[16] && !start_zero;
      len_zero   = (cfg.window_length == '0);

      if (start_zero) begin
         begin_s = '0;
      end else if (start_pos) begin
         begin_s = start_s - 19'sd1;
      end else begin
         begin_s = src_s + start_s;
      end

      len0_s    = len_zero ? src_s : len_s;
      end_raw_s = begin_s + len0_s;

      if (begin_s < 0 && len_zero) begin
         end_s = src_s;
      end else if (end_raw_s > src_s) begin
         end_s = src_s;
      end else begin
         end_s = end_raw_s;
      end

      first_s = (begin_s < 0) ? 19'sd0 : begin_s;

      win_in.empty    = (end_s <= first_s);
      win_in.first    = first_s[15:0];
      win_in.last_pos = 16'(end_s - 19'sd1);
   end

   // Window test on the held word.
   always_comb begin
      p_cmp     = CMP_WIDTH'(hold_pos_ff);
      first_cmp = CMP_WIDTH'(win_ff.first);
      last_cmp  = CMP_WIDTH'(win_ff.last_pos);
      bad       = cfg.window_length[16];
      in_win    = !win_ff.empty && (p_cmp >= first_cmp) && (p_cmp <= last_cmp);

      out_item.is_load      = !word_ff.mode;
      out_item.map_index    = word_ff.map_index;
      out_item.in_map_byte  = word_ff.in_map_byte;
      out_item.out_map_byte = word_ff.out_map_byte;
      out_item.data_byte    = word_ff.data_byte;
      out_item.kept         = word_ff.mode && !bad && in_win;
      out_item.last_kept    = out_item.kept && (p_cmp == last_cmp);
      out_item.status       = word_ff.mode && bad;
      out_item.result       = out_item.kept ? word_ff.data_byte : 8'd0;
      out_item.found        = 1'b0;
   end

   assign out_valid = hold_valid_ff;

endmodule

/* hdl/stc_cell.sv */
// One map cell: holds a match/replace pair and compares the passing word.
module stc_cell #(
   parameter int CELL_ID = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  stc_pkg::item_type     in_item,
   input  stc_pkg::cell_cfg_type cfg,
   output logic                 out_valid,
   output stc_pkg::item_type     out_item
);
   import stc_pkg::*;

   localparam logic [8:0] CELL_POS = 9'(CELL_ID);

   logic [7:0] match_ff, replace_ff;
   logic       valid_ff, valid_in;
   item_type   item_ff, item_in;
   logic       hit, load_here;

   always_comb begin
      load_here = advance && in_valid && in_item.is_load &&
                  ({3'b000, in_item.map_index} == CELL_POS);
      hit = in_item.kept && !in_item.found &&
            ({2'b00, cfg.in_map_len} > CELL_POS) && (match_ff == in_item.data_byte);

      item_in       = in_item;
      item_in.found = in_item.found || hit;
      if (hit) begin
         item_in.result = ({2'b00, cfg.out_map_len} > CELL_POS) ? replace_ff : cfg.pad_byte;
      end
   end

   assign valid_in = advance ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         item_ff <= item_in;
      end
      if (load_here) begin
         match_ff   <= in_item.in_map_byte;
         replace_ff <= in_item.out_map_byte;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule
